// ===== sv/arq_pkg.sv =====
// shared types, constants and helpers for the ack retransmit queue unit
// no dependencies; imported by every module of the block
package arq_pkg;

  localparam int PRIO_DEPTH = 100;
  localparam int NORM_DEPTH = 5;
  localparam int MEM_DEPTH  = PRIO_DEPTH + NORM_DEPTH;
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int MAX_DEPTH  = (PRIO_DEPTH > NORM_DEPTH) ? PRIO_DEPTH : NORM_DEPTH;
  localparam int CW         = $clog2(MAX_DEPTH + 1);
  localparam int PW         = $clog2(PRIO_DEPTH + 1);
  localparam int NW         = $clog2(NORM_DEPTH + 1);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 27;

  localparam logic [CFG_IW-1:0] REG_BACKOFF_BASE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_BACKOFF_SPAN = 2'd1;
  localparam logic [CFG_IW-1:0] REG_OWN_SERIAL   = 2'd2;

  localparam logic [15:0] BASE_RESET   = 16'd1500;
  localparam logic [15:0] SPAN_RESET   = 16'd2000;
  localparam logic [26:0] SERIAL_RESET = 27'd20260002;

  localparam logic [31:0] LFSR_SEED = 32'h2F6E2B1D;
  localparam logic [31:0] LFSR_MASK = 32'h80200003;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_ACK   = 2'd2;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_STORED  = 3'd1;
  localparam logic [2:0] ST_EVICTED = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_SENT    = 3'd4;
  localparam logic [2:0] ST_EXPIRED = 3'd5;
  localparam logic [2:0] ST_ACKED   = 3'd6;
  localparam logic [2:0] ST_IGNORED = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] msg_uid;
    logic [31:0] payload_ref;
    logic        is_priority;
    logic [3:0]  retry_limit;
    logic [26:0] ack_serial;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_uid;
    logic [31:0] out_payload;
    logic [7:0]  attempt;
    logic        from_priority;
  } res_t;

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] payload;
    logic [7:0]  tries;
    logic [3:0]  limit;
  } entry_t;

  typedef struct packed {
    logic         wr_en;
    logic [AW-1:0] wr_addr;
    entry_t       wr_data;
    logic [AW-1:0] rd_addr;
  } mem_ctl_t;

  function automatic logic [31:0] lfsr_step(input logic [31:0] x);
    lfsr_step = x[0] ? ((x >> 1) ^ LFSR_MASK) : (x >> 1);
  endfunction

endpackage

// ===== sv/arq_mem.sv =====
// entry store for both queues: priority entries first, normal entries after
// depends on arq_pkg
module arq_mem (
  input  logic            clk,
  input  arq_pkg::mem_ctl_t ctl,
  output arq_pkg::entry_t rd_data
);
  import arq_pkg::*;

  entry_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

endmodule

// ===== sv/arq_mod_unit.sv =====
// bit-serial remainder unit: 32-bit value modulo 16-bit span, one bit a cycle
// depends on arq_pkg
module arq_mod_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);
  import arq_pkg::*;

  logic        run_r, run_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[31]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // restoring step
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = 16'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[15:0];
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = (div_r == 16'd0) ? 16'd0 : rem_r;

endmodule

// ===== sv/ack_retransmit_queue_unit.sv =====
// top level of the ack retransmit queue: sequencer, queue state and outputs
// depends on arq_pkg, arq_mem and arq_mod_unit
//
// Requests are taken when start is high and busy is low; each request gives
// exactly one result, shown on out_res for one cycle with out_strobe high.
// The receiver cannot stall, so the result must be captured in that cycle.
// A tick that stays idle, an unused op and an ack with a foreign serial
// answer in the cycle after acceptance. Other requests run through a single
// entry memory with one read and one write port: a uid search reads the
// entries of the chosen queue one after another (an ack tries the priority
// queue, then the normal one), a removal shifts the later entries down at
// one entry a cycle, and a send reloads the backoff through a bit-serial
// remainder unit. Worst case is a store into a full priority queue.
// No clearing pass is needed after reset.
module ack_retransmit_queue_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  arq_pkg::req_t              in_req,
  output logic                       out_strobe,
  output arq_pkg::res_t              out_res,
  input  logic                       cfg_we,
  input  logic [arq_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [arq_pkg::CFG_DW-1:0] cfg_wdata
);
  import arq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HRD   = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;
  localparam logic [2:0] S_MOD   = 3'd6;

  localparam logic [1:0] M_TICK  = 2'd0;
  localparam logic [1:0] M_STORE = 2'd1;
  localparam logic [1:0] M_ACK   = 2'd2;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          qsel_r, qsel_nxt;   // 0 priority queue, 1 normal queue
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          evict_r, evict_nxt;
  logic [31:0]   rep_uid_r, rep_uid_nxt;
  req_t          req_r, req_nxt;
  logic [PW-1:0] pfill_r, pfill_nxt;
  logic [NW-1:0] nfill_r, nfill_nxt;
  logic [16:0]   wait_r, wait_nxt;
  logic [31:0]   lfsr_r, lfsr_nxt;
  logic [15:0]   base_r, base_nxt;
  logic [15:0]   span_r, span_nxt;
  logic [26:0]   serial_r, serial_nxt;
  logic          strobe_r, strobe_nxt;
  res_t          res_r, res_nxt;

  mem_ctl_t      mctl;
  entry_t        rd_data;
  logic          mod_start;
  logic          mod_done;
  logic [15:0]   mod_rem;
  logic [31:0]   lfsr_stepped;
  logic [16:0]   wdec;
  logic [CW-1:0] fsel;
  logic          full_sel;
  logic          issue;
  entry_t        head_upd;

  function automatic logic [AW-1:0] qaddr(input logic sel, input logic [CW-1:0] i);
    qaddr = AW'(i) + (sel ? AW'(PRIO_DEPTH) : AW'(0));
  endfunction

  arq_mem u_mem (
    .clk     (clk),
    .ctl     (mctl),
    .rd_data (rd_data)
  );

  arq_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (lfsr_stepped),
    .divisor   (span_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign lfsr_stepped = lfsr_step(lfsr_r);
  assign wdec         = (wait_r != 17'd0) ? wait_r - 17'd1 : 17'd0;
  assign fsel         = qsel_r ? CW'(nfill_r) : CW'(pfill_r);
  assign full_sel     = qsel_r ? (nfill_r == NW'(NORM_DEPTH)) : (pfill_r == PW'(PRIO_DEPTH));
  assign issue        = (idx_r < fsel);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    qsel_nxt    = qsel_r;
    idx_nxt     = idx_r;
    rd_idx_nxt  = rd_idx_r;
    rd_v_nxt    = 1'b0;
    k_nxt       = k_r;
    evict_nxt   = evict_r;
    rep_uid_nxt = rep_uid_r;
    req_nxt     = req_r;
    pfill_nxt   = pfill_r;
    nfill_nxt   = nfill_r;
    wait_nxt    = wait_r;
    lfsr_nxt    = lfsr_r;
    base_nxt    = base_r;
    span_nxt    = span_r;
    serial_nxt  = serial_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    mod_start   = 1'b0;
    mctl        = '0;
    head_upd    = rd_data;

    // configuration writes: the user must write only while idle; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_BACKOFF_BASE: base_nxt   = cfg_wdata[15:0];
        REG_BACKOFF_SPAN: span_nxt   = cfg_wdata[15:0];
        REG_OWN_SERIAL:   serial_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          evict_nxt = 1'b0;
          res_nxt   = '0;
          unique case (in_req.op)
            OP_TICK: begin
              wait_nxt = wdec;
              mode_nxt = M_TICK;
              if (wdec != 17'd0 || (pfill_r == '0 && nfill_r == '0)) begin
                strobe_nxt = 1'b1;
              end else begin
                qsel_nxt  = (pfill_r == '0);
                state_nxt = S_HRD;
              end
            end
            OP_STORE: begin
              mode_nxt  = M_STORE;
              qsel_nxt  = !in_req.is_priority;
              state_nxt = S_SRCH;
            end
            OP_ACK: begin
              mode_nxt = M_ACK;
              qsel_nxt = 1'b0;
              if (in_req.ack_serial == serial_r) begin
                state_nxt = S_SRCH;
              end else begin
                res_nxt.status  = ST_IGNORED;
                res_nxt.out_uid = in_req.msg_uid;
                strobe_nxt      = 1'b1;
              end
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end

      S_HRD: begin
        mctl.rd_addr = qaddr(qsel_r, '0);
        state_nxt    = S_HEAD;
      end

      S_HEAD: begin
        if (qsel_r && (rd_data.tries >= {4'd0, rd_data.limit})) begin
          // expired normal head: drop it without a send
          k_nxt     = '0;
          idx_nxt   = '0;
          state_nxt = S_SHIFT;
        end else begin
          head_upd.tries = (rd_data.tries == 8'hFF) ? 8'hFF : rd_data.tries + 8'd1;
          mctl.wr_en     = 1'b1;
          mctl.wr_addr   = qaddr(qsel_r, '0);
          mctl.wr_data   = head_upd;
          res_nxt.status        = ST_SENT;
          res_nxt.out_uid       = rd_data.uid;
          res_nxt.out_payload   = rd_data.payload;
          res_nxt.attempt       = head_upd.tries;
          res_nxt.from_priority = !qsel_r;
          lfsr_nxt  = lfsr_stepped;
          mod_start = 1'b1;
          state_nxt = S_MOD;
        end
      end

      S_MOD: begin
        if (mod_done) begin
          wait_nxt   = {1'b0, base_r} + {1'b0, mod_rem};
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_SRCH: begin
        mctl.rd_addr = qaddr(qsel_r, idx_r);
        rd_v_nxt     = issue;
        rd_idx_nxt   = idx_r;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (rd_v_r && rd_data.uid == req_r.msg_uid) begin
          rd_v_nxt = 1'b0;
          if (mode_r == M_STORE) begin
            res_nxt.status        = ST_DUP;
            res_nxt.out_uid       = req_r.msg_uid;
            res_nxt.from_priority = !qsel_r;
            strobe_nxt            = 1'b1;
            state_nxt             = S_IDLE;
          end else begin
            k_nxt     = rd_idx_r;
            idx_nxt   = rd_idx_r;
            state_nxt = S_SHIFT;
          end
        end else if (!rd_v_r && !issue) begin
          // uid not in this queue
          if (mode_r == M_STORE) begin
            if (full_sel) begin
              evict_nxt = 1'b1;
              k_nxt     = '0;
              idx_nxt   = '0;
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_INS;
            end
          end else if (!qsel_r) begin
            qsel_nxt = 1'b1;
            idx_nxt  = '0;
          end else begin
            res_nxt.status  = ST_IGNORED;
            res_nxt.out_uid = req_r.msg_uid;
            strobe_nxt      = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // read entry i, write it back one place lower in the next cycle; entry k is dropped, its uid kept
        mctl.rd_addr = qaddr(qsel_r, idx_r);
        rd_v_nxt     = issue;
        rd_idx_nxt   = idx_r;
        if (issue) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (rd_v_r) begin
          if (rd_idx_r == k_r) begin
            rep_uid_nxt = rd_data.uid;
          end else begin
            mctl.wr_en   = 1'b1;
            mctl.wr_addr = qaddr(qsel_r, rd_idx_r - CW'(1));
            mctl.wr_data = rd_data;
          end
        end else if (!issue) begin
          if (qsel_r) begin
            nfill_nxt = nfill_r - NW'(1);
          end else begin
            pfill_nxt = pfill_r - PW'(1);
          end
          unique case (mode_r)
            M_STORE: state_nxt = S_INS;
            M_ACK: begin
              res_nxt.status        = ST_ACKED;
              res_nxt.out_uid       = req_r.msg_uid;
              res_nxt.from_priority = !qsel_r;
              strobe_nxt            = 1'b1;
              state_nxt             = S_IDLE;
            end
            default: begin
              res_nxt.status  = ST_EXPIRED;
              res_nxt.out_uid = rep_uid_r;
              strobe_nxt      = 1'b1;
              state_nxt       = S_IDLE;
            end
          endcase
        end
      end

      S_INS: begin
        mctl.wr_en           = 1'b1;
        mctl.wr_addr         = qaddr(qsel_r, fsel);
        mctl.wr_data.uid     = req_r.msg_uid;
        mctl.wr_data.payload = req_r.payload_ref;
        mctl.wr_data.tries   = 8'd0;
        mctl.wr_data.limit   = req_r.retry_limit;
        if (qsel_r) begin
          nfill_nxt = nfill_r + NW'(1);
        end else begin
          pfill_nxt = pfill_r + PW'(1);
        end
        res_nxt.status        = evict_r ? ST_EVICTED : ST_STORED;
        res_nxt.out_uid       = evict_r ? rep_uid_r : req_r.msg_uid;
        res_nxt.from_priority = !qsel_r;
        strobe_nxt            = 1'b1;
        state_nxt             = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_v_r   <= 1'b0;
      pfill_r  <= '0;
      nfill_r  <= '0;
      wait_r   <= '0;
      lfsr_r   <= LFSR_SEED;
      base_r   <= BASE_RESET;
      span_r   <= SPAN_RESET;
      serial_r <= SERIAL_RESET;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= rd_v_nxt;
      pfill_r  <= pfill_nxt;
      nfill_r  <= nfill_nxt;
      wait_r   <= wait_nxt;
      lfsr_r   <= lfsr_nxt;
      base_r   <= base_nxt;
      span_r   <= span_nxt;
      serial_r <= serial_nxt;
      strobe_r <= strobe_nxt;
    end
    mode_r    <= mode_nxt;
    qsel_r    <= qsel_nxt;
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    k_r       <= k_nxt;
    evict_r   <= evict_nxt;
    rep_uid_r <= rep_uid_nxt;
    req_r     <= req_nxt;
    res_r     <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  // fill counts stay within the queue depths
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pfill_r <= PW'(PRIO_DEPTH)) && (nfill_r <= NW'(NORM_DEPTH)))
    else $error("queue fill count beyond depth");

  // remainder unit finishes only while a send waits for it
  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder result with no send pending");

  // a tick while the backoff count is above one answers idle in the next cycle
  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.op == OP_TICK && wait_r > 17'd1)
      |=> (out_strobe && out_res.status == ST_IDLE))
    else $error("tick during backoff not answered idle");

endmodule
